/* rtl/core/fifo_replacement_queue_assert.svh */
// assertion macros for the fifo replacement queue checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef FIFO_REPLACEMENT_QUEUE_ASSERT_SVH
`define FIFO_REPLACEMENT_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FRQ_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frq assertion failed");

// next-cycle implication, disabled while in reset
`define FRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frq assertion failed");

`endif

/* rtl/core/frq_pkg.sv */
// shared types and constants of the fifo replacement queue
// no dependencies
`default_nettype none

package frq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned KeyW       = 32;
  localparam int unsigned EntryCntW  = 7;

  // operation codes, code 3 is ignored by the block
  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_POP    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOTFOUND = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    func_e             func;
    logic [KeyW-1:0]   key;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [KeyW-1:0]        popped_key;
    logic [KeyW-1:0]        head_key;
    logic                   head_valid;
    logic [EntryCntW-1:0]   entry_count;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/fifo_replacement_queue.sv */
// fifo replacement queue top level: key store, read pipeline and sequencer
// depends on frq_pkg
`default_nettype none

// Keeps cached keys in FIFO replacement order, oldest first at slot zero of a
// single key memory with one write port and one registered read port. A request
// is taken when start_i is high and busy_o is low; exactly one response follows,
// shown on rsp_o for one cycle with done_o high, and it must be taken in that
// cycle since the block cannot be held off. Append, ignored codes, a pop from an
// empty queue and an append to a full queue go from idle straight to the done
// state. Pop and remove walk the memory through the one read port and close the
// gap one entry per cycle. No clearing pass after reset: slots at or above the
// count are never read.
module fifo_replacement_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire frq_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output frq_pkg::rsp_t      rsp_o
);

  localparam int unsigned AW = frq_pkg::AddrW;
  localparam int unsigned CW = frq_pkg::CountW;
  localparam int unsigned KW = frq_pkg::KeyW;
  localparam int unsigned EW = frq_pkg::EntryCntW;

  // sequencer: search walks for the oldest match, shift closes the gap
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       occ_q, occ_d;      // entries held
  logic [KW-1:0]       head_q, head_d;    // copy of slot zero
  logic [KW-1:0]       key_q;             // key of the request at work
  frq_pkg::status_e    status_q, status_d;
  logic [KW-1:0]       popped_q, popped_d;

  // read pipeline: pointer of next read, slot of data in flight
  logic [CW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic                rd_issue;

  // key memory
  logic [KW-1:0]       mem [frq_pkg::QueueDepth];
  logic [KW-1:0]       rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [KW-1:0]       mem_wdata;

  logic                accept;
  logic                hit;

  assign accept = start_i && (state_q == ST_IDLE);
  // the one shared comparator, fed by the registered read data
  assign hit    = rd_vld_q && (rdata_q == key_q);

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    head_d    = head_q;
    status_d  = status_q;
    popped_d  = popped_q;
    rd_ptr_d  = rd_ptr_q;
    rd_idx_d  = rd_idx_q;
    rd_issue  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = occ_q[AW-1:0];
    mem_wdata = req_i.key;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          status_d = frq_pkg::STATUS_OK;
          popped_d = '0;
          state_d  = ST_DONE;
          case (req_i.func)
            frq_pkg::FUNC_APPEND: begin
              if (occ_q >= CW'(frq_pkg::QueueDepth)) begin
                status_d = frq_pkg::STATUS_FULL;
              end else begin
                mem_we = 1'b1;
                occ_d  = occ_q + CW'(1);
                if (occ_q == '0) begin
                  head_d = req_i.key;
                end
              end
            end
            frq_pkg::FUNC_REMOVE: begin
              rd_ptr_d = '0;
              state_d  = ST_SEARCH;
            end
            frq_pkg::FUNC_POP: begin
              if (occ_q == '0) begin
                status_d = frq_pkg::STATUS_EMPTY;
              end else begin
                popped_d = head_q;
                rd_ptr_d = CW'(1);
                state_d  = ST_SHIFT;
              end
            end
            default: begin
              // unused code: report current state only
            end
          endcase
        end
      end
      ST_SEARCH: begin
        rd_issue = rd_ptr_q < occ_q;
        if (hit) begin
          // the read already in flight is the first entry to move down
          state_d = ST_SHIFT;
        end else if (!rd_vld_q && !rd_issue) begin
          status_d = frq_pkg::STATUS_NOTFOUND;
          state_d  = ST_DONE;
        end
      end
      ST_SHIFT: begin
        rd_issue = rd_ptr_q < occ_q;
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_q - AW'(1);
          mem_wdata = rdata_q;
          if (rd_idx_q == AW'(1)) begin
            head_d = rdata_q;
          end
        end
        if (!rd_vld_q && !rd_issue) begin
          occ_d   = occ_q - CW'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    rd_vld_d = rd_issue;
    if (rd_issue) begin
      rd_ptr_d = rd_ptr_q + CW'(1);
      rd_idx_d = rd_ptr_q[AW-1:0];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      occ_q    <= '0;
      rd_ptr_q <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      rd_ptr_q <= rd_ptr_d;
      rd_idx_q <= rd_idx_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    head_q   <= head_d;
    status_q <= status_d;
    popped_q <= popped_d;
    if (accept) begin
      key_q <= req_i.key;
    end
  end

  // key memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_ptr_q[AW-1:0]];
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  always_comb begin
    rsp_o.status      = status_q;
    rsp_o.popped_key  = popped_q;
    rsp_o.head_valid  = (occ_q != '0);
    rsp_o.head_key    = (occ_q != '0) ? head_q : '0;
    rsp_o.entry_count = EW'(occ_q);
  end

endmodule

`default_nettype wire

/* rtl/core/frq_checker.sv */
// port-level checker for the fifo replacement queue, bound to the top level
// depends on frq_pkg and fifo_replacement_queue_assert.svh
`default_nettype none

`include "fifo_replacement_queue_assert.svh"

module frq_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire logic          busy_o,
  input wire logic          done_o,
  input wire frq_pkg::rsp_t rsp_o
);

  localparam int unsigned EW = frq_pkg::EntryCntW;

  // a transfer makes the block busy until its response
  `FRQ_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)

  // response is a single strobe, then the block is free again
  `FRQ_ASSERT_NEXT(a_done_frees, done_o, !busy_o && !done_o)

  // head flag agrees with the count
  `FRQ_ASSERT_IMPLY(a_head_count, done_o, rsp_o.head_valid == (rsp_o.entry_count != '0))

  // full is only reported with every slot taken
  `FRQ_ASSERT_IMPLY(a_full_count, done_o && (rsp_o.status == frq_pkg::STATUS_FULL),
    rsp_o.entry_count == EW'(frq_pkg::QueueDepth))

  // nothing is popped unless the pop succeeded
  `FRQ_ASSERT_IMPLY(a_pop_zero, done_o && (rsp_o.status != frq_pkg::STATUS_OK),
    rsp_o.popped_key == '0)

endmodule

bind fifo_replacement_queue frq_checker u_frq_checker (.*);

`default_nettype wire
